[src/change_dispense_engine_unit_macros.svh]
// Assertion macros shared by the change dispense engine modules.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef CHANGE_DISPENSE_ENGINE_UNIT_MACROS_SVH
`define CHANGE_DISPENSE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cde_pkg.sv]
// Shared constants, codes and controller/datapath types of the change dispense engine.
// No dependencies.
`default_nettype none

package cde_pkg;

	localparam int NUM_DENOMS_DEF = 8;
	localparam int COUNT_BITS_DEF = 16;
	localparam int NUM_REGS       = 8;
	localparam int REG_IDX_BITS   = 3;
	localparam int DENOM_BITS     = 20;
	localparam int QTY_BITS       = 16;
	localparam int AMT_BITS       = 24;
	localparam int PIECE_BITS     = 16;
	localparam int REQ_BITS       = 2;
	localparam int STATUS_BITS    = 2;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_RESTOCK    = 2'd0,
		REQ_PAY_AMOUNT = 2'd1,
		REQ_PAY_QTY    = 2'd2
	} req_kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		RS_OK      = 2'd0,
		RS_UNKNOWN = 2'd1,
		RS_ZERO    = 2'd2,
		RS_SHORT   = 2'd3
	} rsp_status_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_DISPATCH,
		CS_SINGLE,
		CS_AMT_ERR,
		CS_SLOT,
		CS_DIV,
		CS_CLAMP,
		CS_SUB,
		CS_CHECK,
		CS_COMMIT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_LOOKUP,
		DP_WALK_INIT,
		DP_SKIP,
		DP_DIV_START,
		DP_CLAMP,
		DP_SUB,
		DP_COMMIT_INIT,
		DP_EMIT_SINGLE,
		DP_EMIT_ERR,
		DP_EMIT_TAKE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   advance;
	} cmd_t;

	typedef struct packed {
		logic [REQ_BITS-1:0] req_type;
		logic                amt_zero;
		logic                slot_skip;
		logic                slot_last;
		logic                div_done;
		logic                rem_zero;
		logic                take_zero;
		logic                slot_final;
		logic                out_free;
	} sts_t;

endpackage

`default_nettype wire

[src/change_dispense_engine_unit.sv]
// Top level of the change dispense engine: controller plus datapath.
// Depends on cde_pkg, cde_ctrl, cde_datapath (and through it cde_divider).
//
// channel  direction  handshake               contents
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data (slot value in cents)
// req      in         req_valid / req_stall   req_type, denom_cents, quantity, amount_cents
// rsp      out        rsp_valid / rsp_stall   status, slot_denom_cents, pieces, count_left, last
//
// One request at a time. Restock and quantity payout: request latched, slot looked up, then the
// result registered once the result register is free. Amount payout: per used slot with pieces
// held, a 24-step restoring divider, clamp and multiply, subtract; other slots are skipped; a
// check step, then a commit walk emitting one result per paying slot up to the last paying one.
// Reset clears slot values, piece counts and the result valid flag at once.
// A held result stalls only emission; the next request is taken once the last result is in
// the result register.
`default_nettype none

module change_dispense_engine_unit #(
	parameter int NUM_DENOMS = cde_pkg::NUM_DENOMS_DEF,
	parameter int COUNT_BITS = cde_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cde_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [cde_pkg::DENOM_BITS-1:0]    cfg_data,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [cde_pkg::REQ_BITS-1:0]      req_type,
	input  wire logic [cde_pkg::DENOM_BITS-1:0]    denom_cents,
	input  wire logic [cde_pkg::QTY_BITS-1:0]      quantity,
	input  wire logic [cde_pkg::AMT_BITS-1:0]      amount_cents,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic      [cde_pkg::STATUS_BITS-1:0]   status,
	output logic      [cde_pkg::DENOM_BITS-1:0]    slot_denom_cents,
	output logic      [cde_pkg::PIECE_BITS-1:0]    pieces,
	output logic      [cde_pkg::PIECE_BITS-1:0]    count_left,
	output logic                                   last
);

	cde_pkg::cmd_t cmd;
	cde_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cde_datapath #(
		.NUM_DENOMS (NUM_DENOMS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_type         (req_type),
		.denom_cents      (denom_cents),
		.quantity         (quantity),
		.amount_cents     (amount_cents),
		.cmd              (cmd),
		.sts              (sts),
		.rsp_stall        (rsp_stall),
		.rsp_valid        (rsp_valid),
		.status           (status),
		.slot_denom_cents (slot_denom_cents),
		.pieces           (pieces),
		.count_left       (count_left),
		.last             (last)
	);

endmodule

`default_nettype wire

[src/cde_divider.sv]
// Restoring divider, one quotient bit per cycle, for the amount payout walk.
// Depends on cde_pkg.
`default_nettype none

module cde_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [cde_pkg::AMT_BITS-1:0]   dividend,
	input  wire logic [cde_pkg::DENOM_BITS-1:0] divisor,
	output logic      [cde_pkg::AMT_BITS-1:0]   quotient,
	output logic                                done
);

	localparam int AW = cde_pkg::AMT_BITS;
	localparam int DW = cde_pkg::DENOM_BITS;
	localparam int SW = $clog2(AW);
	localparam logic [SW-1:0] STEP_LAST = SW'(AW - 1);

	logic          busy_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] acc_q;
	logic [AW-1:0] quo_q;
	logic [DW-1:0] div_q;

	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          ge;

	always_comb begin
		trial = {acc_q, quo_q[AW-1]};
		diff  = {1'b0, trial} - {2'b00, div_q};
		ge    = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SW'(1);
			if (step_q == STEP_LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			acc_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[AW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = busy_q && (step_q == STEP_LAST);

endmodule

`default_nettype wire

[src/cde_datapath.sv]
// Datapath: slot values, piece counts, request latch, payout walk and result register.
// Depends on cde_pkg, cde_divider and the assertion macros.
`default_nettype none
`include "change_dispense_engine_unit_macros.svh"

module cde_datapath #(
	parameter int NUM_DENOMS = cde_pkg::NUM_DENOMS_DEF,
	parameter int COUNT_BITS = cde_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [cde_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [cde_pkg::DENOM_BITS-1:0]    cfg_data,
	input  wire logic [cde_pkg::REQ_BITS-1:0]      req_type,
	input  wire logic [cde_pkg::DENOM_BITS-1:0]    denom_cents,
	input  wire logic [cde_pkg::QTY_BITS-1:0]      quantity,
	input  wire logic [cde_pkg::AMT_BITS-1:0]      amount_cents,
	input  wire cde_pkg::cmd_t                     cmd,
	output cde_pkg::sts_t                          sts,
	input  wire logic                              rsp_stall,
	output logic                                   rsp_valid,
	output logic      [cde_pkg::STATUS_BITS-1:0]   status,
	output logic      [cde_pkg::DENOM_BITS-1:0]    slot_denom_cents,
	output logic      [cde_pkg::PIECE_BITS-1:0]    pieces,
	output logic      [cde_pkg::PIECE_BITS-1:0]    count_left,
	output logic                                   last
);

	localparam int SLOT_BITS = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
	localparam int AW        = cde_pkg::AMT_BITS;
	localparam int DW        = cde_pkg::DENOM_BITS;
	localparam int QW        = cde_pkg::QTY_BITS;
	localparam int PB        = cde_pkg::PIECE_BITS;
	localparam int RIB       = cde_pkg::REG_IDX_BITS;
	localparam int CMP_W     = (COUNT_BITS > AW) ? COUNT_BITS : AW;
	localparam int PROD_W    = COUNT_BITS + DW;
	localparam logic [SLOT_BITS-1:0]  SLOT_LAST = SLOT_BITS'(NUM_DENOMS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	function automatic logic [PB-1:0] low_piece(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+PB-1:0] w;
		w = {{PB{1'b0}}, v};
		return w[PB-1:0];
	endfunction

	logic [DW-1:0]         denom_q [cde_pkg::NUM_REGS];
	logic [COUNT_BITS-1:0] count_q [NUM_DENOMS];
	logic [COUNT_BITS-1:0] take_q  [NUM_DENOMS];

	logic [cde_pkg::REQ_BITS-1:0] type_q;
	logic [DW-1:0]                dc_q;
	logic [QW-1:0]                qty_q;
	logic [AW-1:0]                amt_q;
	logic [SLOT_BITS-1:0]         slot_q;
	logic [SLOT_BITS-1:0]         final_q;
	logic                         hit_q;
	logic [AW-1:0]                rem_q;
	logic [PROD_W-1:0]            prod_q;

	logic                            rsp_valid_q;
	logic [cde_pkg::STATUS_BITS-1:0] rsp_status_q;
	logic [DW-1:0]                   rsp_denom_q;
	logic [PB-1:0]                   rsp_pieces_q;
	logic [PB-1:0]                   rsp_left_q;
	logic                            rsp_last_q;

	logic [DW-1:0]         denom_cur;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] take_cur;
	logic                  hit_c;
	logic [SLOT_BITS-1:0]  idx_c;
	logic [CMP_W-1:0]      cnt_w;
	logic [CMP_W-1:0]      qty_w;
	logic [CMP_W-1:0]      room_w;
	logic [CMP_W-1:0]      add_w;
	logic [CMP_W-1:0]      quo_w;
	logic [CMP_W-1:0]      take_w;
	logic [COUNT_BITS-1:0] add_c;
	logic [COUNT_BITS-1:0] restock_cnt;
	logic [COUNT_BITS-1:0] payq_cnt;
	logic [COUNT_BITS-1:0] take_c;
	logic [COUNT_BITS-1:0] commit_cnt;
	logic                  short_c;
	logic                  qty_zero;
	logic                  emit_c;
	logic                  out_free_c;
	logic [AW-1:0]         quotient;
	logic                  div_done;

	cde_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == cde_pkg::DP_DIV_START),
		.dividend (rem_q),
		.divisor  (denom_cur),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		hit_c = 1'b0;
		idx_c = '0;
		for (int i = NUM_DENOMS - 1; i >= 0; i--) begin
			if ((dc_q != '0) && (denom_q[i] == dc_q)) begin
				hit_c = 1'b1;
				idx_c = SLOT_BITS'(i);
			end
		end
	end

	always_comb begin
		denom_cur   = denom_q[RIB'(slot_q)];
		cnt_cur     = count_q[slot_q];
		take_cur    = take_q[slot_q];
		cnt_w       = CMP_W'(cnt_cur);
		qty_w       = CMP_W'(qty_q);
		room_w      = CMP_W'(COUNT_MAX - cnt_cur);
		add_w       = (qty_w < room_w) ? qty_w : room_w;
		add_c       = add_w[COUNT_BITS-1:0];
		restock_cnt = cnt_cur + add_c;
		short_c     = qty_w > cnt_w;
		payq_cnt    = cnt_cur - qty_w[COUNT_BITS-1:0];
		quo_w       = CMP_W'(quotient);
		take_w      = (quo_w > cnt_w) ? cnt_w : quo_w;
		take_c      = take_w[COUNT_BITS-1:0];
		commit_cnt  = cnt_cur - take_cur;
		qty_zero    = qty_q == '0;
		out_free_c  = !rsp_valid_q || !rsp_stall;
		emit_c      = (cmd.op == cde_pkg::DP_EMIT_SINGLE) || (cmd.op == cde_pkg::DP_EMIT_ERR) ||
		              (cmd.op == cde_pkg::DP_EMIT_TAKE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cde_pkg::NUM_REGS; i++)
				denom_q[i] <= '0;
			for (int i = 0; i < NUM_DENOMS; i++)
				count_q[i] <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				denom_q[cfg_index] <= cfg_data;
			case (cmd.op)
				cde_pkg::DP_EMIT_SINGLE: begin
					if (hit_q && !qty_zero) begin
						if (type_q == cde_pkg::REQ_RESTOCK)
							count_q[slot_q] <= restock_cnt;
						else if (!short_c)
							count_q[slot_q] <= payq_cnt;
					end
				end
				cde_pkg::DP_EMIT_TAKE: count_q[slot_q] <= commit_cnt;
				default: ;
			endcase
			if (emit_c)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			cde_pkg::DP_LOAD: begin
				type_q <= req_type;
				dc_q   <= denom_cents;
				qty_q  <= quantity;
				amt_q  <= amount_cents;
			end
			cde_pkg::DP_LOOKUP: begin
				hit_q  <= hit_c;
				slot_q <= idx_c;
			end
			cde_pkg::DP_WALK_INIT: begin
				slot_q <= '0;
				rem_q  <= amt_q;
			end
			cde_pkg::DP_SKIP: take_q[slot_q] <= '0;
			cde_pkg::DP_CLAMP: begin
				take_q[slot_q] <= take_c;
				prod_q         <= PROD_W'(take_c) * PROD_W'(denom_cur);
			end
			cde_pkg::DP_SUB: begin
				rem_q <= rem_q - prod_q[AW-1:0];
				if (take_cur != '0)
					final_q <= slot_q;
			end
			cde_pkg::DP_COMMIT_INIT: slot_q <= '0;
			cde_pkg::DP_EMIT_SINGLE: begin
				rsp_denom_q <= dc_q;
				rsp_last_q  <= 1'b1;
				if (!hit_q) begin
					rsp_status_q <= cde_pkg::RS_UNKNOWN;
					rsp_pieces_q <= '0;
					rsp_left_q   <= '0;
				end else if (qty_zero) begin
					rsp_status_q <= cde_pkg::RS_ZERO;
					rsp_pieces_q <= '0;
					rsp_left_q   <= low_piece(cnt_cur);
				end else if (type_q == cde_pkg::REQ_RESTOCK) begin
					rsp_status_q <= cde_pkg::RS_OK;
					rsp_pieces_q <= low_piece(add_c);
					rsp_left_q   <= low_piece(restock_cnt);
				end else if (short_c) begin
					rsp_status_q <= cde_pkg::RS_SHORT;
					rsp_pieces_q <= '0;
					rsp_left_q   <= low_piece(cnt_cur);
				end else begin
					rsp_status_q <= cde_pkg::RS_OK;
					rsp_pieces_q <= qty_q;
					rsp_left_q   <= low_piece(payq_cnt);
				end
			end
			cde_pkg::DP_EMIT_ERR: begin
				rsp_status_q <= (amt_q == '0) ? cde_pkg::RS_ZERO : cde_pkg::RS_SHORT;
				rsp_denom_q  <= '0;
				rsp_pieces_q <= '0;
				rsp_left_q   <= '0;
				rsp_last_q   <= 1'b1;
			end
			cde_pkg::DP_EMIT_TAKE: begin
				rsp_status_q <= cde_pkg::RS_OK;
				rsp_denom_q  <= denom_cur;
				rsp_pieces_q <= low_piece(take_cur);
				rsp_left_q   <= low_piece(commit_cnt);
				rsp_last_q   <= slot_q == final_q;
			end
			default: ;
		endcase
		if (cmd.advance)
			slot_q <= slot_q + SLOT_BITS'(1);
	end

	always_comb begin
		sts.req_type   = type_q;
		sts.amt_zero   = amt_q == '0;
		sts.slot_skip  = (denom_cur == '0) || (cnt_cur == '0);
		sts.slot_last  = slot_q == SLOT_LAST;
		sts.div_done   = div_done;
		sts.rem_zero   = rem_q == '0;
		sts.take_zero  = take_cur == '0;
		sts.slot_final = slot_q == final_q;
		sts.out_free   = out_free_c;
	end

	assign rsp_valid        = rsp_valid_q;
	assign status           = rsp_status_q;
	assign slot_denom_cents = rsp_denom_q;
	assign pieces           = rsp_pieces_q;
	assign count_left       = rsp_left_q;
	assign last             = rsp_last_q;

	`CDE_ASSERT_IMPL(a_emit_when_free, emit_c, out_free_c, "result written over a held result")
	`CDE_ASSERT_IMPL(a_take_within_count, cmd.op == cde_pkg::DP_EMIT_TAKE, take_cur <= cnt_cur,
		"payout exceeds pieces held")
	`CDE_ASSERT_NEXT(a_rem_not_growing, cmd.op == cde_pkg::DP_SUB, rem_q <= $past(rem_q),
		"remaining amount grew")

endmodule

`default_nettype wire

[src/cde_ctrl.sv]
// Controller state machine: request intake, payout walk sequencing and result emission.
// Depends on cde_pkg and the assertion macros.
`default_nettype none
`include "change_dispense_engine_unit_macros.svh"

module cde_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire cde_pkg::sts_t sts,
	output cde_pkg::cmd_t      cmd
);

	cde_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cde_pkg::CS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cde_pkg::CS_IDLE: begin
				if (req_valid)
					state_d = cde_pkg::CS_DISPATCH;
			end
			cde_pkg::CS_DISPATCH: begin
				case (sts.req_type)
					cde_pkg::REQ_RESTOCK, cde_pkg::REQ_PAY_QTY: state_d = cde_pkg::CS_SINGLE;
					cde_pkg::REQ_PAY_AMOUNT:
						state_d = sts.amt_zero ? cde_pkg::CS_AMT_ERR : cde_pkg::CS_SLOT;
					default: state_d = cde_pkg::CS_IDLE;
				endcase
			end
			cde_pkg::CS_SINGLE, cde_pkg::CS_AMT_ERR: begin
				if (sts.out_free)
					state_d = cde_pkg::CS_IDLE;
			end
			cde_pkg::CS_SLOT: begin
				if (!sts.slot_skip)
					state_d = cde_pkg::CS_DIV;
				else if (sts.slot_last)
					state_d = cde_pkg::CS_CHECK;
			end
			cde_pkg::CS_DIV: begin
				if (sts.div_done)
					state_d = cde_pkg::CS_CLAMP;
			end
			cde_pkg::CS_CLAMP: state_d = cde_pkg::CS_SUB;
			cde_pkg::CS_SUB: state_d = sts.slot_last ? cde_pkg::CS_CHECK : cde_pkg::CS_SLOT;
			cde_pkg::CS_CHECK: state_d = sts.rem_zero ? cde_pkg::CS_COMMIT : cde_pkg::CS_AMT_ERR;
			cde_pkg::CS_COMMIT: begin
				if (!sts.take_zero && sts.out_free && sts.slot_final)
					state_d = cde_pkg::CS_IDLE;
			end
			default: state_d = cde_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = cde_pkg::DP_NOP;
		cmd.advance = 1'b0;
		req_stall   = 1'b1;
		case (state_q)
			cde_pkg::CS_IDLE: begin
				req_stall = 1'b0;
				if (req_valid)
					cmd.op = cde_pkg::DP_LOAD;
			end
			cde_pkg::CS_DISPATCH: begin
				case (sts.req_type)
					cde_pkg::REQ_RESTOCK, cde_pkg::REQ_PAY_QTY: cmd.op = cde_pkg::DP_LOOKUP;
					cde_pkg::REQ_PAY_AMOUNT: begin
						if (!sts.amt_zero)
							cmd.op = cde_pkg::DP_WALK_INIT;
					end
					default: ;
				endcase
			end
			cde_pkg::CS_SINGLE: begin
				if (sts.out_free)
					cmd.op = cde_pkg::DP_EMIT_SINGLE;
			end
			cde_pkg::CS_AMT_ERR: begin
				if (sts.out_free)
					cmd.op = cde_pkg::DP_EMIT_ERR;
			end
			cde_pkg::CS_SLOT: begin
				if (sts.slot_skip) begin
					cmd.op      = cde_pkg::DP_SKIP;
					cmd.advance = !sts.slot_last;
				end else begin
					cmd.op = cde_pkg::DP_DIV_START;
				end
			end
			cde_pkg::CS_CLAMP: cmd.op = cde_pkg::DP_CLAMP;
			cde_pkg::CS_SUB: begin
				cmd.op      = cde_pkg::DP_SUB;
				cmd.advance = !sts.slot_last;
			end
			cde_pkg::CS_CHECK: begin
				if (sts.rem_zero)
					cmd.op = cde_pkg::DP_COMMIT_INIT;
			end
			cde_pkg::CS_COMMIT: begin
				if (sts.take_zero) begin
					cmd.advance = 1'b1;
				end else if (sts.out_free) begin
					cmd.op      = cde_pkg::DP_EMIT_TAKE;
					cmd.advance = !sts.slot_final;
				end
			end
			default: ;
		endcase
	end

	`CDE_ASSERT_IMPL(a_div_done_in_div, sts.div_done, state_q == cde_pkg::CS_DIV,
		"divider finished outside the divide state")
	`CDE_ASSERT_IMPL(a_commit_exact, state_q == cde_pkg::CS_COMMIT, sts.rem_zero,
		"commit of an inexact payout")

endmodule

`default_nettype wire

[bench/change_dispense_engine_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for change_dispense_engine_unit: restock, quantity and amount payouts
// over several slot value settings, with random gaps and stalls on both channels.
// Depends on cde_pkg and the change_dispense_engine_unit RTL.

module change_dispense_engine_unit_tb;

	localparam int RW = cde_pkg::REQ_BITS;
	localparam int DW = cde_pkg::DENOM_BITS;
	localparam int QW = cde_pkg::QTY_BITS;
	localparam int AW = cde_pkg::AMT_BITS;
	localparam int PW = cde_pkg::PIECE_BITS;
	localparam logic [RW-1:0] REQ_UNDEFINED = 2'd3;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		cde_pkg::rsp_status_t status;
		logic [DW-1:0]        denom;
		logic [PW-1:0]        pieces;
		logic [PW-1:0]        left;
		logic                 last;
	} payout_rec_t;

	class payout_scoreboard;
		logic [DW-1:0] denom [cde_pkg::NUM_REGS];
		logic [PW-1:0] count [cde_pkg::NUM_DENOMS_DEF];
		payout_rec_t expected_payouts [$];
		int errors;

		function new();
			foreach (denom[i]) denom[i] = '0;
			foreach (count[i]) count[i] = '0;
			errors = 0;
		endfunction

		function void write_denom(int idx, logic [DW-1:0] value);
			denom[idx] = value;
		endfunction

		function int find_slot(logic [DW-1:0] cents);
			if (cents == 0)
				return -1;
			for (int i = 0; i < cde_pkg::NUM_DENOMS_DEF; i++)
				if (denom[i] == cents)
					return i;
			return -1;
		endfunction

		function int pending();
			return expected_payouts.size();
		endfunction

		function void queue_payout(cde_pkg::rsp_status_t st, logic [DW-1:0] dc,
				logic [PW-1:0] pc, logic [PW-1:0] left, logic lst);
			payout_rec_t rec;
			rec.status = st;
			rec.denom  = dc;
			rec.pieces = pc;
			rec.left   = left;
			rec.last   = lst;
			expected_payouts.push_back(rec);
		endfunction

		// Predict the results of one accepted request and update the held counts.
		function void note_request(logic [RW-1:0] kind, logic [DW-1:0] dc,
				logic [QW-1:0] qty, logic [AW-1:0] amt);
			int s;
			int final_slot;
			logic [PW-1:0] cnt;
			logic [PW-1:0] room;
			logic [PW-1:0] add;
			longint unsigned rem;
			longint unsigned t;
			longint unsigned take [cde_pkg::NUM_DENOMS_DEF];
			case (kind)
				cde_pkg::REQ_RESTOCK, cde_pkg::REQ_PAY_QTY: begin
					s = find_slot(dc);
					if (s < 0) begin
						queue_payout(cde_pkg::RS_UNKNOWN, dc, '0, '0, 1'b1);
					end else begin
						cnt = count[s];
						if (qty == 0) begin
							queue_payout(cde_pkg::RS_ZERO, dc, '0, cnt, 1'b1);
						end else if (kind == cde_pkg::REQ_RESTOCK) begin
							room = '1 - cnt;
							add = (qty < room) ? qty : room;
							count[s] = cnt + add;
							queue_payout(cde_pkg::RS_OK, dc, add, count[s], 1'b1);
						end else if (qty > cnt) begin
							queue_payout(cde_pkg::RS_SHORT, dc, '0, cnt, 1'b1);
						end else begin
							count[s] = cnt - qty;
							queue_payout(cde_pkg::RS_OK, dc, qty, count[s], 1'b1);
						end
					end
				end
				cde_pkg::REQ_PAY_AMOUNT: begin
					if (amt == 0) begin
						queue_payout(cde_pkg::RS_ZERO, '0, '0, '0, 1'b1);
					end else begin
						rem = amt;
						final_slot = -1;
						for (int i = 0; i < cde_pkg::NUM_DENOMS_DEF; i++) begin
							t = 0;
							if (denom[i] != 0) begin
								t = rem / denom[i];
								if (t > count[i])
									t = count[i];
								rem -= t * denom[i];
							end
							take[i] = t;
							if (t != 0)
								final_slot = i;
						end
						if (rem != 0) begin
							queue_payout(cde_pkg::RS_SHORT, '0, '0, '0, 1'b1);
						end else begin
							for (int i = 0; i < cde_pkg::NUM_DENOMS_DEF; i++) begin
								if (take[i] != 0) begin
									count[i] = count[i] - take[i][PW-1:0];
									queue_payout(cde_pkg::RS_OK, denom[i], take[i][PW-1:0],
										count[i], i == final_slot);
								end
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void report_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, name, want, got);
			end
		endfunction

		function void check_payout(payout_rec_t got);
			payout_rec_t want;
			if (expected_payouts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual status %0d denom %0d",
					$time, got.status, got.denom);
				return;
			end
			want = expected_payouts.pop_front();
			report_field("status", want.status, got.status);
			report_field("slot_denom_cents", want.denom, got.denom);
			report_field("pieces", want.pieces, got.pieces);
			report_field("count_left", want.left, got.left);
			report_field("last", want.last, got.last);
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [cde_pkg::REG_IDX_BITS-1:0] cfg_index;
	logic [DW-1:0]                    cfg_data;
	logic                             req_valid;
	logic                             req_stall;
	logic [RW-1:0]                    req_type;
	logic [DW-1:0]                    denom_cents;
	logic [QW-1:0]                    quantity;
	logic [AW-1:0]                    amount_cents;
	logic                             rsp_valid;
	logic                             rsp_stall;
	logic [cde_pkg::STATUS_BITS-1:0]  status;
	logic [DW-1:0]                    slot_denom_cents;
	logic [PW-1:0]                    pieces;
	logic [PW-1:0]                    count_left;
	logic                             last;

	payout_scoreboard sb = new();
	logic [DW-1:0] denom_plan [cde_pkg::NUM_REGS];
	bit no_idle;
	int rsp_hold_cycles;

	change_dispense_engine_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.denom_cents(denom_cents),
		.quantity(quantity),
		.amount_cents(amount_cents),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.slot_denom_cents(slot_denom_cents),
		.pieces(pieces),
		.count_left(count_left),
		.last(last)
	);

	always #5 clk = ~clk;

	task automatic load_denoms();
		for (int i = 0; i < cde_pkg::NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[cde_pkg::REG_IDX_BITS-1:0];
			cfg_data  <= denom_plan[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.write_denom(i, denom_plan[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_request(input logic [RW-1:0] kind, input logic [DW-1:0] dc,
			input logic [QW-1:0] qty, input logic [AW-1:0] amt);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= kind;
		denom_cents  <= dc;
		quantity     <= qty;
		amount_cents <= amt;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(kind, dc, qty, amt);
	endtask

	task automatic settle(input int extra);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic random_request(output bit counted);
		int r;
		int s;
		int cnt;
		longint unsigned sum;
		logic [RW-1:0] kind;
		logic [DW-1:0] dc;
		logic [QW-1:0] qty;
		logic [AW-1:0] amt;
		r = $urandom_range(0, 99);
		dc = sb.denom[$urandom_range(0, cde_pkg::NUM_REGS - 1)];
		if ($urandom_range(0, 9) == 0)
			dc = DW'($urandom_range(0, 20'hFFFFF));
		qty = QW'($urandom_range(1, 40));
		amt = AW'($urandom);
		if (r < 4) begin
			kind = REQ_UNDEFINED;
			dc = DW'($urandom);
			qty = QW'($urandom);
		end else if (r < 10) begin
			kind = RW'($urandom_range(0, 2));
			dc = DW'($urandom);
			qty = QW'($urandom);
		end else if (r < 40) begin
			kind = cde_pkg::REQ_RESTOCK;
			case ($urandom_range(0, 19))
				0: qty = '0;
				1: qty = '1;
				2: qty = QW'($urandom);
				default: ;
			endcase
		end else if (r < 65) begin
			kind = cde_pkg::REQ_PAY_QTY;
			s = sb.find_slot(dc);
			cnt = (s >= 0) ? int'(sb.count[s]) : 5;
			qty = QW'($urandom_range(1, cnt + 3));
			if ($urandom_range(0, 19) == 0)
				qty = '0;
		end else begin
			kind = cde_pkg::REQ_PAY_AMOUNT;
			sum = 0;
			for (int i = 0; i < cde_pkg::NUM_DENOMS_DEF; i++)
				if (sb.denom[i] != 0 && $urandom_range(0, 1) == 1)
					sum += 64'(sb.denom[i]) *
						64'($urandom_range(0, (sb.count[i] < 12) ? sb.count[i] : 12));
			case ($urandom_range(0, 19))
				0: amt = '0;
				1: ;
				2: amt = sum[AW-1:0] + AW'(1);
				default: amt = (sum == 0) ? AW'($urandom_range(1, 1000)) : sum[AW-1:0];
			endcase
		end
		counted = (kind != REQ_UNDEFINED);
		send_request(kind, dc, qty, amt);
	endtask

	task automatic run_random(input int n);
		int done;
		bit counted;
		done = 0;
		while (done < n) begin
			random_request(counted);
			if (counted)
				done++;
		end
	endtask

	// Result side: random stalls, one long hold-off on request, check every transaction.
	initial begin
		int k;
		payout_rec_t got;
		rsp_stall = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_cycles > 0) begin
				k = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				k = no_idle ? 0 : $urandom_range(0, 7);
			end
			if (k > 0) begin
				rsp_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			got.status = cde_pkg::rsp_status_t'(status);
			got.denom  = slot_denom_cents;
			got.pieces = pieces;
			got.left   = count_left;
			got.last   = last;
			sb.check_payout(got);
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req_type = cde_pkg::REQ_RESTOCK;
		denom_cents = '0;
		quantity = '0;
		amount_cents = '0;
		no_idle = 1'b0;
		rsp_hold_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		denom_plan = '{20'hFFFFF, 10000, 2000, 500, 100, 25, 5, 1};
		load_denoms();
		send_request(cde_pkg::REQ_RESTOCK, 20'hFFFFF, 16'hFFFF, '0);
		send_request(cde_pkg::REQ_RESTOCK, 20'hFFFFF, 1, '0);
		send_request(cde_pkg::REQ_RESTOCK, 1, 0, '0);
		send_request(cde_pkg::REQ_RESTOCK, 7, 3, '0);
		send_request(cde_pkg::REQ_RESTOCK, 0, 5, '0);
		send_request(cde_pkg::REQ_PAY_QTY, 25, 5, '0);
		send_request(cde_pkg::REQ_RESTOCK, 25, 100, '0);
		send_request(cde_pkg::REQ_PAY_QTY, 25, 100, '0);
		send_request(cde_pkg::REQ_PAY_QTY, 20'hFFFFF, 0, '0);
		send_request(cde_pkg::REQ_PAY_QTY, 0, 1, '0);
		send_request(cde_pkg::REQ_PAY_AMOUNT, '0, '0, '0);
		send_request(REQ_UNDEFINED, '1, '1, '1);
		send_request(cde_pkg::REQ_RESTOCK, 10000, 3, '0);
		send_request(cde_pkg::REQ_RESTOCK, 2000, 4, '0);
		send_request(cde_pkg::REQ_RESTOCK, 500, 2, '0);
		send_request(cde_pkg::REQ_RESTOCK, 100, 7, '0);
		send_request(cde_pkg::REQ_RESTOCK, 25, 9, '0);
		send_request(cde_pkg::REQ_RESTOCK, 5, 1, '0);
		send_request(cde_pkg::REQ_RESTOCK, 1, 16'hFFFF, '0);
		send_request(cde_pkg::REQ_PAY_AMOUNT, '0, '0, 24'hFFFFFF);
		send_request(cde_pkg::REQ_PAY_AMOUNT, '0, '0, 1061206);
		send_request(cde_pkg::REQ_PAY_AMOUNT, '0, '0, 3);
		send_request(cde_pkg::REQ_PAY_QTY, 1, 16'hFFFF, '0);
		send_request(cde_pkg::REQ_PAY_QTY, 10000, 1, '0);
		run_random(100);
		settle(SETTLE_CYCLES);

		// Coin set: every slot holds a value, so amount payouts can use every slot; hold results back to fill up.
		denom_plan = '{200, 100, 50, 20, 10, 5, 2, 1};
		load_denoms();
		rsp_hold_cycles = 400;
		run_random(100);
		settle(SETTLE_CYCLES);

		// Unused slots and duplicated values; drain fully halfway.
		denom_plan = '{0, 500, 500, 0, 50, 0, 7, 0};
		load_denoms();
		run_random(40);
		settle(0);
		run_random(40);
		settle(SETTLE_CYCLES);

		denom_plan = '{0, 0, 0, 0, 0, 0, 0, 0};
		load_denoms();
		run_random(20);
		settle(SETTLE_CYCLES);

		denom_plan = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
			20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
		load_denoms();
		run_random(60);
		settle(SETTLE_CYCLES);

		foreach (denom_plan[i])
			denom_plan[i] = DW'($urandom_range(1, 5000));
		denom_plan.rsort();
		load_denoms();
		no_idle = 1'b1;
		run_random(60);
		no_idle = 1'b0;
		settle(SETTLE_CYCLES);

		foreach (denom_plan[i])
			denom_plan[i] = ($urandom_range(0, 9) < 3) ? '0 : DW'($urandom_range(1, 20'hFFFFF));
		load_denoms();
		run_random(60);
		settle(SETTLE_CYCLES);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("change_dispense_engine_unit_tb OK");
		else
			$display("change_dispense_engine_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("change_dispense_engine_unit_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/cde_pkg.sv
src/cde_divider.sv
src/cde_datapath.sv
src/cde_ctrl.sv
src/change_dispense_engine_unit.sv
bench/change_dispense_engine_unit_tb.sv
